FILE: rtl/core/alir_pkg.sv
// Package for the array list block: operation and status codes, controller states,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package alir_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int POS_W = 7;
  localparam int WORD_W = 32;
  localparam int COUNT_OUT_W = 8;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REV_RD,
    S_REV_WLO,
    S_REV_WHI,
    S_READ_WAIT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    ins_init;
    logic    shift_rd;
    logic    shift_wr;
    logic    ins_put;
    logic    rev_init;
    logic    rev_rd;
    logic    rev_wlo;
    logic    rev_whi;
    logic    rd_issue;
    logic    finish;
    logic    fin_read;
    status_t fin_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic pos_bad;
    logic idx_bad;
    logic shift_more;
    logic rev_more;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/alir_datapath.sv
// Datapath of the array list block: element memory, entry count, walk pointers
// and result registers. Depends on alir_pkg.
`default_nettype none

module alir_datapath
  import alir_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  input  wire logic [1:0]               operation,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic [POS_W-1:0]         position,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [WORD_W-1:0]      read_value,
  output logic [COUNT_OUT_W-1:0]        count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [CW-1:0]     entries;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     lo_dec;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] value_q;
  op_t               op_q;

  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re_a;
  logic [AW-1:0]     raddr_a;

  status_t           status_q;
  logic [WORD_W-1:0] read_value_q;
  logic              done_q;

  assign lo_dec = lo - CW'(1);

  always_comb begin
    we    = cmd.ins_put | cmd.shift_wr | cmd.rev_wlo | cmd.rev_whi;
    waddr = lo[AW-1:0];
    wdata = rdata_a;
    if (cmd.ins_put) begin
      waddr = AW'(pos_q);
      wdata = value_q;
    end else if (cmd.rev_wlo) begin
      wdata = rdata_b;
    end else if (cmd.rev_whi) begin
      waddr = hi[AW-1:0];
    end
    re_a    = cmd.shift_rd | cmd.rev_rd | cmd.rd_issue;
    raddr_a = lo[AW-1:0];
    if (cmd.shift_rd) begin
      raddr_a = lo_dec[AW-1:0];
    end else if (cmd.rd_issue) begin
      raddr_a = AW'(pos_q);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (cmd.rev_rd) begin
      rdata_b <= mem[hi[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
      done_q  <= 1'b0;
      op_q    <= OP_CLEAR;
    end else begin
      done_q <= cmd.finish;
      if (cmd.load) begin
        op_q <= op_t'(operation);
      end
      if (cmd.clear) begin
        entries <= '0;
      end else if (cmd.ins_put) begin
        entries <= entries + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_q   <= position;
      value_q <= value;
    end
    if (cmd.ins_init) begin
      lo <= entries;
    end else if (cmd.shift_wr) begin
      lo <= lo_dec;
    end else if (cmd.rev_init) begin
      lo <= '0;
    end else if (cmd.rev_whi) begin
      lo <= lo + CW'(1);
    end
    if (cmd.rev_init) begin
      hi <= entries - CW'(1);
    end else if (cmd.rev_whi) begin
      hi <= hi - CW'(1);
    end
    if (cmd.finish) begin
      status_q     <= cmd.fin_status;
      read_value_q <= cmd.fin_read ? rdata_a : '0;
    end
  end

  always_comb begin
    sts.op         = op_q;
    sts.full       = (entries == CW'(CAPACITY));
    sts.pos_bad    = (LW'(pos_q) > LW'(entries));
    sts.idx_bad    = (LW'(pos_q) >= LW'(entries));
    sts.shift_more = (LW'(lo) > LW'(pos_q));
    sts.rev_more   = (lo < (entries >> 1));
  end

  assign done       = done_q;
  assign status     = status_q;
  assign read_value = read_value_q;
  assign count      = COUNT_OUT_W'(entries);

endmodule

`default_nettype wire

FILE: rtl/core/alir_ctrl.sv
// Controller of the array list block: command decode and the walks for insert
// shifting and reversal. Depends on alir_pkg.
`default_nettype none

module alir_ctrl
  import alir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_OK;
            state_next     = S_IDLE;
          end
          OP_INSERT: begin
            if (sts.full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_FULL;
              state_next     = S_IDLE;
            end else if (sts.pos_bad) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_BAD_POS;
              state_next     = S_IDLE;
            end else begin
              cmd.ins_init = 1'b1;
              state_next   = S_SHIFT_RD;
            end
          end
          OP_REVERSE: begin
            cmd.rev_init = 1'b1;
            state_next   = S_REV_RD;
          end
          OP_READ: begin
            if (sts.idx_bad) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_BAD_INDEX;
              state_next     = S_IDLE;
            end else begin
              cmd.rd_issue = 1'b1;
              state_next   = S_READ_WAIT;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (sts.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          cmd.ins_put    = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_REV_RD: begin
        if (sts.rev_more) begin
          cmd.rev_rd = 1'b1;
          state_next = S_REV_WLO;
        end else begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_next     = S_IDLE;
        end
      end
      S_REV_WLO: begin
        cmd.rev_wlo = 1'b1;
        state_next  = S_REV_WHI;
      end
      S_REV_WHI: begin
        cmd.rev_whi = 1'b1;
        state_next  = S_REV_RD;
      end
      S_READ_WAIT: begin
        cmd.finish     = 1'b1;
        cmd.fin_read   = 1'b1;
        cmd.fin_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/array_list_insert_reverse.sv
// Top level of the array list block: controller and datapath joined by command and
// status structs. Depends on alir_pkg, alir_ctrl and alir_datapath.
//
//   Channel   Handshake        Fields
//   command   start / busy     operation, value, position
//   result    done (strobe)    status, read_value, count
//
// An item is taken on a rising edge with start high and busy low; its result is
// shown for one cycle with done high. Clear and rejected commands end at dispatch,
// a read waits for its memory read, an insert moves each element above position up
// by a read and a write, and a reverse swaps each pair by a read and two writes; the
// single write port of the element memory sets the insert and reverse walks.
// Reset clears the count and the controller; the memory is not cleared.
// The receiver cannot stall: results are never held.
`default_nettype none

module array_list_insert_reverse
  import alir_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               operation,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic [POS_W-1:0]         position,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [WORD_W-1:0]      read_value,
  output logic [COUNT_OUT_W-1:0]        count
);

  cmd_t cmd;
  sts_t sts;

  alir_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  alir_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (operation),
    .value      (value),
    .position   (position),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

endmodule

`default_nettype wire

FILE: rtl/core/alir_checker.sv
// Port-level checker for the array list block, with the bind that attaches it to
// the top level. Depends on alir_pkg and array_list_insert_reverse.
`default_nettype none

module alir_checker
  import alir_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done,
  input wire logic [1:0]               status,
  input wire logic signed [WORD_W-1:0] read_value,
  input wire logic [COUNT_OUT_W-1:0]   count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the end of a command");

  a_value_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && read_value != 0 |-> status == ST_OK)
    else $error("nonzero read value with an error status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> count == COUNT_OUT_W'(CAPACITY))
    else $error("list full reported below capacity");

endmodule

bind array_list_insert_reverse alir_checker #(
  .CAPACITY (CAPACITY)
) u_alir_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .read_value (read_value),
  .count      (count)
);

`default_nettype wire

FILE: tb/alir_list_checker.sv
// Checker for the array list block: watches the command and result channels,
// keeps its own copy of the list and compares each result with its prediction.
// Depends on alir_pkg.
module alir_list_checker
  import alir_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic                     busy,
  input  wire logic [1:0]               operation,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic                     done,
  input  wire logic [1:0]               status,
  input  wire logic signed [WORD_W-1:0] read_value,
  input  wire logic [COUNT_OUT_W-1:0]   count,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct {
    status_t                  code;
    logic signed [WORD_W-1:0] word;
    logic [COUNT_OUT_W-1:0]   total;
  } answer_t;

  logic signed [WORD_W-1:0] list_words [CAPACITY_DEF];
  int list_len = 0;
  int errors_seen = 0;
  answer_t expected_answers [$];

  function automatic answer_t apply_command(op_t op, logic signed [WORD_W-1:0] word, int at);
    answer_t a;
    logic signed [WORD_W-1:0] held;
    int hi;
    a.code = ST_OK;
    a.word = '0;
    case (op)
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_INSERT: begin
        if (list_len >= CAPACITY_DEF) begin
          a.code = ST_FULL;
        end else if (at > list_len) begin
          a.code = ST_BAD_POS;
        end else begin
          for (int k = list_len; k > at; k--) list_words[k] = list_words[k-1];
          list_words[at] = word;
          list_len++;
        end
      end
      OP_REVERSE: begin
        for (int lo = 0; lo < list_len / 2; lo++) begin
          hi = list_len - 1 - lo;
          held = list_words[lo];
          list_words[lo] = list_words[hi];
          list_words[hi] = held;
        end
      end
      default: begin
        if (at >= list_len) a.code = ST_BAD_INDEX;
        else a.word = list_words[at];
      end
    endcase
    a.total = COUNT_OUT_W'(list_len);
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      expected_answers.delete();
      list_len = 0;
    end else begin
      if (done) begin
        if (expected_answers.size() == 0) begin
          $error("Result arrived with no command waiting for one.");
          errors_seen++;
        end else begin
          want = expected_answers.pop_front();
          if (status !== want.code) begin
            $error("status: expected %0d, actual %0d", want.code, status);
            errors_seen++;
          end
          if (read_value !== want.word) begin
            $error("read_value: expected %0d, actual %0d", want.word, read_value);
            errors_seen++;
          end
          if (count !== want.total) begin
            $error("count: expected %0d, actual %0d", want.total, count);
            errors_seen++;
          end
        end
      end
      if (start && !busy) begin
        expected_answers.push_back(apply_command(op_t'(operation), value, int'(position)));
      end
    end
    mismatches <= errors_seen;
    outstanding <= expected_answers.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the array list testbench: drives directed and random commands into the
// block and gives the verdict. Depends on alir_pkg, array_list_insert_reverse
// and alir_list_checker.
module tb_top;
  import alir_pkg::*;

  localparam int RUN_LIMIT = 2_000_000;
  localparam int ITEM_TARGET = 1550;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               operation = OP_CLEAR;
  logic signed [WORD_W-1:0] value = '0;
  logic [POS_W-1:0]         position = '0;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] read_value;
  logic [COUNT_OUT_W-1:0]   count;
  int                       mismatches;
  int                       outstanding;

  int cycle_count = 0;
  int list_len = 0;
  int items_sent = 0;
  int max_gap = 4;

  always #2 clk = ~clk;

  array_list_insert_reverse dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .value      (value),
    .position   (position),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

  alir_list_checker watch (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .value       (value),
    .position    (position),
    .done        (done),
    .status      (status),
    .read_value  (read_value),
    .count       (count),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // The length is tracked here to steer positions toward valid ones and to tell when the list is full.
  task automatic issue(op_t op, logic signed [WORD_W-1:0] word, int at);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    value <= word;
    position <= POS_W'(at);
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (op == OP_CLEAR) begin
      list_len = 0;
    end else if (op == OP_INSERT && list_len < CAPACITY_DEF && at <= list_len) begin
      list_len++;
    end
  endtask

  task automatic fill_list();
    int r;
    if ($urandom_range(0, 1) == 0) issue(OP_CLEAR, pick_word(), $urandom_range(0, 127));
    while (list_len < CAPACITY_DEF) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        issue(OP_INSERT, pick_word(), $urandom_range(0, list_len));
      end else if (r == 8) begin
        issue(OP_READ, pick_word(), $urandom_range(0, list_len));
      end else begin
        issue(OP_REVERSE, pick_word(), $urandom_range(0, 127));
      end
    end
    repeat (3) issue(OP_INSERT, pick_word(), $urandom_range(0, 127));
    issue(OP_REVERSE, pick_word(), $urandom_range(0, 127));
    repeat (4) issue(OP_READ, pick_word(), $urandom_range(0, 127));
  endtask

  task automatic mixed_run(int length);
    int r;
    int at;
    op_t op;
    repeat (length) begin
      r = $urandom_range(0, 19);
      if (r == 0) op = OP_CLEAR;
      else op = op_t'($urandom_range(1, 3));
      if ($urandom_range(0, 1) == 0) at = $urandom_range(0, list_len < 127 ? list_len : 127);
      else at = $urandom_range(0, 127);
      issue(op, pick_word(), at);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    issue(OP_CLEAR, '0, 0);
    issue(OP_READ, '0, 0);
    issue(OP_REVERSE, '0, 0);
    issue(OP_INSERT, 32'sh1234_5678, 1);
    issue(OP_INSERT, 32'sh8000_0000, 0);
    issue(OP_REVERSE, '0, 0);
    issue(OP_INSERT, 32'sh0bad_0bad, 127);
    issue(OP_INSERT, 32'sh7fff_ffff, 1);
    issue(OP_INSERT, -1, 0);
    issue(OP_INSERT, '0, 1);
    issue(OP_REVERSE, -1, 127);
    for (int i = 0; i < 4; i++) issue(OP_READ, '0, i);
    issue(OP_INSERT, 32'sh5555_5555, 2);
    issue(OP_REVERSE, '0, 0);
    issue(OP_READ, -1, 4);
    issue(OP_READ, '0, 5);
    issue(OP_READ, '0, 127);
    issue(OP_CLEAR, -1, 127);
    issue(OP_READ, '0, 0);

    fill_list();
    while (items_sent < ITEM_TARGET) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
      if ($urandom_range(0, 3) == 0) fill_list();
      else mixed_run($urandom_range(20, 60));
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
